// File: rtl/tmcr_pkg.sv
// Package for the tag memory command responder: codes, constants, tables and shared types.
// No dependencies; the receive buffer, the block store and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tmcr_pkg;

   // bus event codes
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_STOP = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // command codes (low nibble of the command byte)
   localparam logic [3:0] CMD_IDENTIFY  = 4'h6;
   localparam logic [3:0] CMD_READ_BLK  = 4'h8;
   localparam logic [3:0] CMD_WRITE_BLK = 4'h9;
   localparam logic [3:0] CMD_NOP_A     = 4'hA;
   localparam logic [3:0] CMD_GET_UID   = 4'hB;
   localparam logic [3:0] CMD_NOP_C     = 4'hC;
   localparam logic [3:0] CMD_SELECT    = 4'hE;
   localparam logic [3:0] CMD_NOP_F     = 4'hF;

   // command frame layout
   localparam int CMD_BYTE_POS   = 2;
   localparam int BLOCK_BYTE_POS = 3;
   localparam int WR_DATA_POS    = 4;
   localparam int MIN_CMD_BYTES  = 3;
   localparam int MIN_RD_BYTES   = 4;
   localparam int MIN_WR_BYTES   = 8;

   // response lengths and fixed bytes
   localparam logic [3:0] NODE_LEN  = 4'd2;
   localparam logic [3:0] UID_LEN   = 4'd9;
   localparam logic [3:0] BLK_LEN   = 4'd5;
   localparam logic [7:0] BLK_HDR   = 8'h04;
   localparam logic [7:0] FILL_BYTE = 8'hFF;
   localparam logic [7:0] DEF_COUNT = 8'h78;

   // physical block store
   localparam int         PHYS_BLOCKS = 6;
   localparam int         ROW_W       = 3;
   localparam logic [2:0] COUNT_ROW   = 3'd1;

   // CSR map
   localparam int         CSR_ADDR_W     = 3;
   localparam logic [2:0] CSR_COUNT_ADDR = 3'd0;

   typedef enum logic [1:0] {
      SRC_NONE  = 2'd0,
      SRC_NODE  = 2'd1,
      SRC_UID   = 2'd2,
      SRC_BLOCK = 2'd3
   } src_type;

   // decoded view of the receive buffer
   typedef struct packed {
      logic        ge_cmd;
      logic        ge_read;
      logic        ge_write;
      logic [3:0]  cmd;
      logic [7:0]  blk_num;
      logic [31:0] wr_data;
   } rx_status_type;

   // block number to physical row
   function automatic logic [2:0] alias_row(input logic [3:0] blk);
      logic [2:0] row;
      case (blk)
         4'd5, 4'd6:        row = 3'd1;
         4'd8, 4'd9, 4'd10: row = 3'd2;
         4'd11, 4'd12:      row = 3'd3;
         4'd13:             row = 3'd4;
         4'd15:             row = 3'd5;
         default:           row = 3'd0;
      endcase
      return row;
   endfunction

   // power-up contents of a row, byte k at bits 8k+7:8k
   function automatic logic [31:0] init_row(input logic [2:0] row);
      logic [31:0] val;
      case (row)
         3'd1:    val = 32'h0000_0078;
         3'd2:    val = 32'h0078_0001;
         3'd3:    val = 32'h0000_0F04;
         3'd4:    val = 32'h2A30_7E1F;
         3'd5:    val = 32'hFC2B_0F04;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] node_byte(input logic idx);
      return idx ? 8'h3C : 8'h01;
   endfunction

   function automatic logic [7:0] uid_byte(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h08;
         4'd1:    val = 8'hA3;
         4'd2:    val = 8'h6E;
         4'd3:    val = 8'h6A;
         4'd4:    val = 8'h73;
         4'd5:    val = 8'h09;
         4'd6:    val = 8'h33;
         4'd7:    val = 8'h02;
         4'd8:    val = 8'hD0;
         default: val = 8'hFF;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: rtl/tmcr_req_if.sv
// Request channel of the tag memory command responder: valid/ready plus bus event payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tmcr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/tmcr_rsp_if.sv
// Response channel of the tag memory command responder: valid/ready plus result payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tmcr_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] read_byte;
   logic       halted;
   logic [7:0] count_value;

   modport source (output valid, output has_byte, output read_byte, output halted,
                   output count_value, input ready);
   modport sink   (input valid, input has_byte, input read_byte, input halted,
                   input count_value, output ready);
endinterface

`default_nettype wire

// File: rtl/tmcr_block_mem.sv
// Physical block store: 6 rows of 4 bytes, registered read, per-row valid bits.
// Depends on tmcr_pkg for the row count and the power-up contents.
`timescale 1ns / 1ps
`default_nettype none

module tmcr_block_mem (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire logic [2:0]  wr_row,
   input  wire logic [31:0] wr_data,
   input  wire logic        rd_en,
   input  wire logic [2:0]  rd_row,
   output      logic [31:0] rd_data
);

   logic [31:0] mem_ff [tmcr_pkg::PHYS_BLOCKS];
   logic [tmcr_pkg::PHYS_BLOCKS-1:0] row_valid_ff;
   logic [31:0] rd_data_ff;
   logic        rd_valid_ff;
   logic [2:0]  rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
         rd_row_ff  <= rd_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_row];
         end
      end
   end

   // rows never written read as their power-up contents
   assign rd_data = rd_valid_ff ? rd_data_ff : tmcr_pkg::init_row(rd_row_ff);

endmodule

`default_nettype wire

// File: rtl/tmcr_rx_buf.sv
// Receive buffer: collects written bytes, drops overflow, presents the decoded frame fields.
// Depends on tmcr_pkg for the frame layout and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module tmcr_rx_buf #(
   parameter int RX_BUF_BYTES = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire logic [7:0]              push_data,
   input  wire logic                    clear,
   output      tmcr_pkg::rx_status_type status
);

   localparam int CNT_W = $clog2(RX_BUF_BYTES + 1);
   localparam int IDX_W = $clog2(RX_BUF_BYTES);

   logic [7:0]       buf_ff [RX_BUF_BYTES];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             room;

   assign room = count_ff < CNT_W'(RX_BUF_BYTES);

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (push && room) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push && room) begin
         buf_ff[count_ff[IDX_W-1:0]] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.ge_cmd   = count_ff >= CNT_W'(tmcr_pkg::MIN_CMD_BYTES);
   assign status.ge_read  = count_ff >= CNT_W'(tmcr_pkg::MIN_RD_BYTES);
   assign status.ge_write = count_ff >= CNT_W'(tmcr_pkg::MIN_WR_BYTES);
   assign status.cmd      = buf_ff[tmcr_pkg::CMD_BYTE_POS][3:0];
   assign status.blk_num  = buf_ff[tmcr_pkg::BLOCK_BYTE_POS];
   assign status.wr_data  = {buf_ff[tmcr_pkg::WR_DATA_POS+3], buf_ff[tmcr_pkg::WR_DATA_POS+2],
                             buf_ff[tmcr_pkg::WR_DATA_POS+1], buf_ff[tmcr_pkg::WR_DATA_POS]};

endmodule

`default_nettype wire

// File: rtl/tag_memory_command_responder.sv
// Top level of the tag memory command responder: request decode, response pointer, CSR port.
// Depends on tmcr_pkg, tmcr_req_if, tmcr_rsp_if, tmcr_rx_buf and tmcr_block_mem.
`timescale 1ns / 1ps
`default_nettype none

// Emulates a serial memory tag seen through a bus slave. Each request is one bus event
// (byte written, stop, read request) and yields exactly one response carrying the read byte
// (when a read request was served), the sticky halt flag and the current count byte (physical
// block one, byte zero). Byte and stop requests, and read requests that hit the node ID, UID,
// block header or fill byte, are answered directly; a read request that returns a stored block
// byte waits in ST_READ, since the block store's read port is registered. The block store comes
// up with its preset contents through per-row valid bits, so there is no clearing pass after
// reset. A malformed read or write command halts the block until reset. The single CSR at
// byte address 0 holds initial_count; writing it reloads the count byte (0 and 0xFF load 120).
// Write the CSR only while no request is in flight.
module tag_memory_command_responder #(
   parameter int RX_BUF_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tmcr_req_if.sink         req,
   tmcr_rsp_if.source       rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [tmcr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10   // waiting on the block store read
   } state_type;

   state_type         state_ff, state_in;
   logic              halt_ff, halt_in;
   tmcr_pkg::src_type src_ff, src_in;
   logic [2:0]        blk_row_ff, blk_row_in;
   logic [3:0]        len_ff, len_in;
   logic [3:0]        idx_ff, idx_in;
   logic [1:0]        lane_ff, lane_in;
   logic [7:0]        count_ff, count_in;
   logic [7:0]        init_count_ff, init_count_in;

   // response holding register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              has_ff, has_in;
   logic [7:0]        rb_ff, rb_in;
   logic              halted_ff, halted_in;
   logic [7:0]        cntv_ff, cntv_in;

   logic              accept;
   logic              work;
   logic              load;
   logic              cfg_wr;
   logic              rx_push, rx_clear;
   tmcr_pkg::rx_status_type rx_stat;
   logic              mem_wr, mem_rd;
   logic [2:0]        row_sel;
   logic              blk_ok;
   logic [31:0]       mem_rd_data;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && (paddr == tmcr_pkg::CSR_COUNT_ADDR);
   assign prdata  = (paddr == tmcr_pkg::CSR_COUNT_ADDR) ? {24'd0, init_count_ff} : 32'd0;

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign work      = accept && !halt_ff;

   assign rx_push  = work && (req.operation == tmcr_pkg::OP_BYTE);
   assign rx_clear = work && (req.operation == tmcr_pkg::OP_STOP);

   // block number must fit in a nibble
   assign row_sel = tmcr_pkg::alias_row(rx_stat.blk_num[3:0]);
   assign blk_ok  = (rx_stat.blk_num[7:4] == 4'd0);

   tmcr_rx_buf #(
      .RX_BUF_BYTES (RX_BUF_BYTES)
   ) u_rx_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .push_data (req.data_byte),
      .clear     (rx_clear),
      .status    (rx_stat)
   );

   tmcr_block_mem u_block_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr),
      .wr_row  (row_sel),
      .wr_data (rx_stat.wr_data),
      .rd_en   (mem_rd),
      .rd_row  (blk_row_ff),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      halt_in       = halt_ff;
      src_in        = src_ff;
      blk_row_in    = blk_row_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      lane_in       = lane_ff;
      count_in      = count_ff;
      init_count_in = init_count_ff;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      load          = 1'b0;
      has_in        = 1'b0;
      rb_in         = 8'd0;

      if (cfg_wr) begin
         init_count_in = pwdata[7:0];
         count_in      = (pwdata[7:0] == 8'h00 || pwdata[7:0] == 8'hFF) ?
                         tmcr_pkg::DEF_COUNT : pwdata[7:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load = 1'b1;
            end
            if (work && req.operation == tmcr_pkg::OP_STOP && rx_stat.ge_cmd) begin
               idx_in = 4'd0;
               case (rx_stat.cmd)
                  tmcr_pkg::CMD_IDENTIFY, tmcr_pkg::CMD_SELECT: begin
                     src_in = tmcr_pkg::SRC_NODE;
                     len_in = tmcr_pkg::NODE_LEN;
                  end
                  tmcr_pkg::CMD_READ_BLK: begin
                     if (rx_stat.ge_read && blk_ok) begin
                        src_in     = tmcr_pkg::SRC_BLOCK;
                        blk_row_in = row_sel;
                        len_in     = tmcr_pkg::BLK_LEN;
                     end else begin
                        halt_in = 1'b1;
                        idx_in  = idx_ff;
                     end
                  end
                  tmcr_pkg::CMD_WRITE_BLK: begin
                     if (rx_stat.ge_write && blk_ok) begin
                        mem_wr = 1'b1;
                        len_in = 4'd0;
                        // count byte lives in its own register
                        if (row_sel == tmcr_pkg::COUNT_ROW) begin
                           count_in = rx_stat.wr_data[7:0];
                        end
                     end else begin
                        halt_in = 1'b1;
                        idx_in  = idx_ff;
                     end
                  end
                  tmcr_pkg::CMD_NOP_A, tmcr_pkg::CMD_NOP_C, tmcr_pkg::CMD_NOP_F: begin
                     len_in = 4'd0;
                  end
                  tmcr_pkg::CMD_GET_UID: begin
                     src_in = tmcr_pkg::SRC_UID;
                     len_in = tmcr_pkg::UID_LEN;
                  end
                  default: begin
                     // unknown command: pointer rewind only
                  end
               endcase
            end
            if (work && req.operation == tmcr_pkg::OP_READ) begin
               has_in = 1'b1;
               rb_in  = tmcr_pkg::FILL_BYTE;
               if (idx_ff < len_ff) begin
                  idx_in = idx_ff + 4'd1;
                  case (src_ff)
                     tmcr_pkg::SRC_NODE: begin
                        if (idx_ff < tmcr_pkg::NODE_LEN) begin
                           rb_in = tmcr_pkg::node_byte(idx_ff[0]);
                        end
                     end
                     tmcr_pkg::SRC_UID: begin
                        if (idx_ff < tmcr_pkg::UID_LEN) begin
                           rb_in = tmcr_pkg::uid_byte(idx_ff);
                        end
                     end
                     tmcr_pkg::SRC_BLOCK: begin
                        if (idx_ff == 4'd0) begin
                           rb_in = tmcr_pkg::BLK_HDR;
                        end else if (idx_ff inside {[4'd1:4'd4]}) begin
                           // stored byte: fetch, answer next cycle
                           mem_rd   = 1'b1;
                           load     = 1'b0;
                           lane_in  = 2'(idx_ff - 4'd1);
                           state_in = ST_READ;
                        end
                     end
                     default: begin
                        rb_in = tmcr_pkg::FILL_BYTE;
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            load     = 1'b1;
            has_in   = 1'b1;
            state_in = ST_IDLE;
            if (blk_row_ff == tmcr_pkg::COUNT_ROW && lane_ff == 2'd0) begin
               rb_in = count_ff;
            end else begin
               rb_in = mem_rd_data[{lane_ff, 3'b000} +: 8];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign halted_in    = halt_in;
   assign cntv_in      = count_in;
   assign rsp_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         halt_ff       <= 1'b0;
         src_ff        <= tmcr_pkg::SRC_NONE;
         len_ff        <= 4'd0;
         idx_ff        <= 4'd0;
         count_ff      <= tmcr_pkg::DEF_COUNT;
         init_count_ff <= tmcr_pkg::DEF_COUNT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         halt_ff       <= halt_in;
         src_ff        <= src_in;
         len_ff        <= len_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         init_count_ff <= init_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_row_ff <= blk_row_in;
      lane_ff    <= lane_in;
      if (load) begin
         has_ff    <= has_in;
         rb_ff     <= rb_in;
         halted_ff <= halted_in;
         cntv_ff   <= cntv_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.has_byte    = has_ff;
   assign rsp.read_byte   = rb_ff;
   assign rsp.halted      = halted_ff;
   assign rsp.count_value = cntv_ff;

`ifndef SYNTHESIS
   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= len_ff)
      else $error("response pointer past response length");

   a_read_follows_accept : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(req.valid && req.ready))
      else $error("block fetch without an accepted request");

   a_read_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid_ff)
      else $error("block fetch produced no response");

   a_halted_no_byte : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && halted_ff && !$past(halt_ff) && has_ff) |-> 1'b0)
      else $error("byte served while halting");
`endif

endmodule

`default_nettype wire
